### design/assert_macros.svh
// ------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the median filter front end and job queue; each use
// expects clk_i and rst_ni in scope
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define MF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### design/mf_pkg.sv
// ------------------------------------------------------------------------
// mf_pkg
// types and constants shared by the 3x3 median filter modules
// ------------------------------------------------------------------------
package mf_pkg;

  // frame geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int PIXEL_BITS  = 8;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WEFF_W      = COL_W + 1;
  localparam int FWIDTH_BITS = 11;
  localparam int FHEIGHT_BITS = 12;
  localparam int IROW_W      = FHEIGHT_BITS + 1;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH) + 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIXEL_BITS-1:0]   pix_t;
  typedef logic [COL_W-1:0]        col_t;
  typedef logic [WEFF_W-1:0]       weff_t;
  typedef logic [IROW_W-1:0]       irow_t;
  typedef logic [FHEIGHT_BITS-1:0] orow_t;
  typedef logic [FIFO_PTR_W-1:0]   fifo_ptr_t;
  typedef logic [FIFO_CNT_W-1:0]   fifo_cnt_t;

  // 3x3 window, rows top to bottom, columns left to right
  typedef logic [8:0][PIXEL_BITS-1:0] window_t;
  typedef logic [2:0][PIXEL_BITS-1:0] pix3_t;

  typedef struct packed {
    logic kind;
    pix_t pixel_value;
  } in_item_t;

  typedef struct packed {
    pix_t filtered_value;
    logic last_of_frame;
  } out_item_t;

  // one output pixel waiting for the median network
  typedef struct packed {
    window_t window;
    logic    interior;
    logic    last;
  } median_job_t;

endpackage

### design/mf_ram.sv
// ------------------------------------------------------------------------
// mf_ram
// generic single write port ram with one registered read port; a read of
// the address being written returns the old contents
// ------------------------------------------------------------------------
module mf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mf_front.sv
// ------------------------------------------------------------------------
// mf_front
// accepts pixel and drain requests, tracks the frame position, keeps the
// two line stores and the sliding window, and queues one job per output
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module mf_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mf_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [mf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mf_pkg::in_item_t                   in_data_i,
  input  mf_pkg::fifo_cnt_t                  fifo_level_i,
  output logic                               job_push_o,
  output mf_pkg::median_job_t                job_o
);

  localparam int P = mf_pkg::PIXEL_BITS;

  typedef struct packed {
    mf_pkg::pix_t pixel;
    mf_pkg::col_t col;
    logic         emit;
    logic         interior;
    logic         last;
  } front_stage_t;

  logic [mf_pkg::FWIDTH_BITS-1:0]  frame_width_q;
  logic [mf_pkg::FHEIGHT_BITS-1:0] frame_height_q;

  mf_pkg::col_t  col_q;
  mf_pkg::irow_t row_q;
  mf_pkg::col_t  ocol_q;
  mf_pkg::orow_t orow_q;

  mf_pkg::weff_t w_eff;
  mf_pkg::orow_t h_eff;

  logic         in_frame, drop, accept, advance;
  logic         emit, interior, last, col_wrap, ocol_wrap;
  mf_pkg::pix_t pix_in;

  front_stage_t      s1_d, s1_q;
  logic              s1_valid_q;
  logic              fwd_hit_q;
  logic [2*P-1:0]    fwd_data_q;
  logic [2*P-1:0]    ram_rdata, line_rd, line_wr;
  mf_pkg::pix_t      upper_rd, middle_rd;
  mf_pkg::window_t   window_q, window_d, win_shift;

  // effective frame size
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = mf_pkg::weff_t'(1);
    end else if (32'(frame_width_q) > mf_pkg::MAX_WIDTH) begin
      w_eff = mf_pkg::weff_t'(mf_pkg::MAX_WIDTH);
    end else begin
      w_eff = mf_pkg::weff_t'(frame_width_q);
    end
    h_eff = (frame_height_q == '0) ? mf_pkg::orow_t'(1) : frame_height_q;
  end

  // request classification
  assign in_stall_o = (int'(fifo_level_i) + int'(s1_valid_q)) >= mf_pkg::FIFO_DEPTH;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_frame   = row_q < {1'b0, h_eff};
  assign drop       = in_data_i.kind && in_frame;
  assign advance    = accept && !drop;
  assign pix_in     = in_frame ? in_data_i.pixel_value : '0;

  // output position lags the input by one row and one pixel
  assign emit     = (row_q >= mf_pkg::irow_t'(2))
                    || ((row_q == mf_pkg::irow_t'(1)) && (col_q != '0));
  assign interior = (orow_q != '0)
                    && (({1'b0, orow_q} + mf_pkg::irow_t'(2)) <= {1'b0, h_eff})
                    && (ocol_q != '0)
                    && (({1'b0, ocol_q} + mf_pkg::weff_t'(2)) <= w_eff);
  assign last     = (orow_q == (h_eff - mf_pkg::orow_t'(1)))
                    && ({1'b0, ocol_q} == (w_eff - mf_pkg::weff_t'(1)));
  assign col_wrap  = ({1'b0, col_q} + mf_pkg::weff_t'(1)) >= w_eff;
  assign ocol_wrap = ({1'b0, ocol_q} + mf_pkg::weff_t'(1)) >= w_eff;

  // configuration and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= mf_pkg::FWIDTH_BITS'(640);
      frame_height_q <= mf_pkg::FHEIGHT_BITS'(480);
      col_q          <= '0;
      row_q          <= '0;
      ocol_q         <= '0;
      orow_q         <= '0;
    end else if (cfg_we_i) begin
      case (mf_pkg::cfg_reg_e'(cfg_addr_i))
        mf_pkg::CFG_FRAME_WIDTH: begin
          frame_width_q <= cfg_data_i[mf_pkg::FWIDTH_BITS-1:0];
        end
        mf_pkg::CFG_FRAME_HEIGHT: begin
          frame_height_q <= cfg_data_i[mf_pkg::FHEIGHT_BITS-1:0];
        end
        default: ;
      endcase
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (advance) begin
      if (emit && last) begin
        col_q  <= '0;
        row_q  <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + mf_pkg::irow_t'(1);
        end else begin
          col_q <= col_q + mf_pkg::col_t'(1);
        end
        if (emit) begin
          if (ocol_wrap) begin
            ocol_q <= '0;
            orow_q <= orow_q + mf_pkg::orow_t'(1);
          end else begin
            ocol_q <= ocol_q + mf_pkg::col_t'(1);
          end
        end
      end
    end
  end

  // line stores: upper row in the high half, middle row in the low half
  mf_ram #(
    .WIDTH (2 * P),
    .DEPTH (mf_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_q.col),
    .wdata_i (line_wr),
    .re_i    (advance),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // stage after the line store read
  assign s1_d = '{pixel: pix_in, col: col_q, emit: emit, interior: interior, last: last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= advance;
      fwd_hit_q  <= advance && s1_valid_q && (col_q == s1_q.col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= s1_d;
    end
    fwd_data_q <= line_wr;
  end

  // bypass the write that landed on the same column as the read
  assign line_rd   = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign upper_rd  = line_rd[2*P-1:P];
  assign middle_rd = line_rd[P-1:0];
  assign line_wr   = {middle_rd, s1_q.pixel};

  // window shift, new column on the right
  always_comb begin
    win_shift = window_q;
    for (int r = 0; r < 3; r++) begin
      win_shift[r*3]     = window_q[r*3+1];
      win_shift[r*3 + 1] = window_q[r*3+2];
    end
    win_shift[2] = upper_rd;
    win_shift[5] = middle_rd;
    win_shift[8] = s1_q.pixel;
  end

  always_comb begin
    window_d = window_q;
    if (cfg_we_i) begin
      window_d = '0;
    end else if (s1_valid_q) begin
      window_d = (s1_q.emit && s1_q.last) ? '0 : win_shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else begin
      window_q <= window_d;
    end
  end

  // job to the queue
  assign job_push_o = s1_valid_q && s1_q.emit;
  assign job_o      = '{window: win_shift, interior: s1_q.interior, last: s1_q.last};

  `MF_ASSERT(a_fwd_needs_stage, fwd_hit_q |-> s1_valid_q, "bypass without a stage item")
  `MF_ASSERT(a_col_in_frame, {1'b0, col_q} < w_eff, "input column beyond frame width")
  `MF_ASSERT(a_ocol_in_frame, {1'b0, ocol_q} < w_eff, "output column beyond frame width")

endmodule

### design/mf_fifo.sv
// ------------------------------------------------------------------------
// mf_fifo
// short job queue between the window front end and the median back end
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module mf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mf_pkg::median_job_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output mf_pkg::median_job_t data_o,
  output mf_pkg::fifo_cnt_t   level_o
);

  mf_pkg::median_job_t entries_q [mf_pkg::FIFO_DEPTH];
  mf_pkg::fifo_ptr_t   wptr_q, rptr_q;
  mf_pkg::fifo_cnt_t   level_q;
  logic                pop;

  assign valid_o = level_q != '0;
  assign data_o  = entries_q[rptr_q];
  assign level_o = level_q;
  assign pop     = valid_o && ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (int'(wptr_q) == mf_pkg::FIFO_DEPTH - 1) ? '0
                  : wptr_q + mf_pkg::fifo_ptr_t'(1);
      end
      if (pop) begin
        rptr_q <= (int'(rptr_q) == mf_pkg::FIFO_DEPTH - 1) ? '0
                  : rptr_q + mf_pkg::fifo_ptr_t'(1);
      end
      if (push_i && !pop) begin
        level_q <= level_q + mf_pkg::fifo_cnt_t'(1);
      end else if (pop && !push_i) begin
        level_q <= level_q - mf_pkg::fifo_cnt_t'(1);
      end
    end
  end

  `MF_ASSERT_NEVER(a_no_overflow, push_i && !pop && (int'(level_q) == mf_pkg::FIFO_DEPTH),
                   "job queue overflow")

endmodule

### design/mf_median.sv
// ------------------------------------------------------------------------
// mf_median
// three stage median of nine network with an output register; border
// pixels bypass the network and take the window centre
// ------------------------------------------------------------------------
module mf_median (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  mf_pkg::median_job_t job_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mf_pkg::out_item_t   out_data_o
);

  typedef struct packed {
    mf_pkg::pix3_t [2:0] rows;
    mf_pkg::pix_t        centre;
    logic                interior;
    logic                last;
  } sorted_t;

  typedef struct packed {
    mf_pkg::pix_t lo;
    mf_pkg::pix_t mid;
    mf_pkg::pix_t hi;
    mf_pkg::pix_t centre;
    logic         interior;
    logic         last;
  } reduced_t;

  function automatic mf_pkg::pix_t min2(mf_pkg::pix_t a, mf_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf_pkg::pix_t max2(mf_pkg::pix_t a, mf_pkg::pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic mf_pkg::pix_t med3(mf_pkg::pix_t a, mf_pkg::pix_t b, mf_pkg::pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // ascending: element 0 smallest
  function automatic mf_pkg::pix3_t sort3(mf_pkg::pix_t a, mf_pkg::pix_t b,
                                          mf_pkg::pix_t c);
    mf_pkg::pix_t lo, hi, t;
    mf_pkg::pix3_t s;
    lo   = min2(a, b);
    hi   = max2(a, b);
    t    = min2(hi, c);
    s[2] = max2(hi, c);
    s[1] = max2(lo, t);
    s[0] = min2(lo, t);
    return s;
  endfunction

  sorted_t           st1_d, st1_q;
  reduced_t          st2_d, st2_q;
  mf_pkg::out_item_t out_d, out_q;
  logic              st1_valid_q, st2_valid_q, out_valid_q;
  logic              st1_ready, st2_ready, out_ready;

  // stall chain
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign st2_ready   = !st2_valid_q || out_ready;
  assign st1_ready   = !st1_valid_q || st2_ready;
  assign job_ready_o = st1_ready;

  // sort each row
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      st1_d.rows[r] = sort3(job_i.window[r*3], job_i.window[r*3+1], job_i.window[r*3+2]);
    end
    st1_d.centre   = job_i.window[4];
    st1_d.interior = job_i.interior;
    st1_d.last     = job_i.last;
  end

  // largest minimum, middle median, smallest maximum
  always_comb begin
    st2_d.lo       = max2(max2(st1_q.rows[0][0], st1_q.rows[1][0]), st1_q.rows[2][0]);
    st2_d.mid      = med3(st1_q.rows[0][1], st1_q.rows[1][1], st1_q.rows[2][1]);
    st2_d.hi       = min2(min2(st1_q.rows[0][2], st1_q.rows[1][2]), st1_q.rows[2][2]);
    st2_d.centre   = st1_q.centre;
    st2_d.interior = st1_q.interior;
    st2_d.last     = st1_q.last;
  end

  // final median or border pass-through
  assign out_d = '{filtered_value: st2_q.interior ? med3(st2_q.lo, st2_q.mid, st2_q.hi)
                                                  : st2_q.centre,
                   last_of_frame: st2_q.last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
      st2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (st1_ready) begin
        st1_valid_q <= job_valid_i;
      end
      if (st2_ready) begin
        st2_valid_q <= st1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= st2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st1_ready && job_valid_i) begin
      st1_q <= st1_d;
    end
    if (st2_ready && st1_valid_q) begin
      st2_q <= st2_d;
    end
    if (out_ready && st2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/median_filter_3x3.sv
// ------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster-order grayscale frame
// ------------------------------------------------------------------------
// One request is taken every clock cycle when the output side keeps up;
// the pace is set by the line store, which is read as a request is taken
// and written back in the next cycle, with a bypass for a back-to-back hit
// on the same column. A pixel's result comes out once the pixel one row
// and one column further on has been taken, so frame_width+1 drain
// requests after the last pixel release the tail of the frame. After
// the request that completes its window, the result passes the line
// store read and window stage, the job queue, two network stages and
// the output register. A drain request that arrives inside the frame
// is taken and dropped; a pixel request after the frame's last pixel
// acts as a drain. Any configuration write restarts the frame. The line
// store needs no clearing pass after reset.
module median_filter_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mf_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [mf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mf_pkg::in_item_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mf_pkg::out_item_t             out_data_o
);

  logic                job_push, job_valid, job_ready;
  mf_pkg::median_job_t job_in, job_out;
  mf_pkg::fifo_cnt_t   fifo_level;

  // window front end
  mf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .fifo_level_i (fifo_level),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  // job queue
  mf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .valid_o (job_valid),
    .ready_i (job_ready),
    .data_o  (job_out),
    .level_o (fifo_level)
  );

  // median back end
  mf_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job_out),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### bench/tb_median_filter_3x3.sv
// ------------------------------------------------------------------------
// tb_median_filter_3x3
// self-checking bench for the 3x3 median filter
// ------------------------------------------------------------------------
// Requests go in on the valid/stall port in bursts of random length. The
// output side stalls on a pattern of its own. A predictor of the filter
// follows every accepted request and every register write. Each result
// is checked, field by field and in order, against the pixel that the
// predictor or the hand-worked table expects.
// The run starts with a table of hand-worked frames. A clamped full-width
// row and a one-column frame follow, and then random frames of many
// shapes, some of them cut short by a register write.
// ------------------------------------------------------------------------
module tb_median_filter_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  import mf_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int RANDOM_ITEMS  = 650;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_MAX    = 10;
  localparam int MAX_STALL_RUN = 6;
  localparam int TABLE_ROWS    = 33;
  localparam int COUNT_W       = 22;

  // request kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [1:0] {OP_PIXEL, OP_DRAIN, OP_SET_WIDTH, OP_SET_HEIGHT} row_op_e;
  typedef enum logic [1:0] {EXP_NONE, EXP_PIXEL, EXP_PREDICT} row_exp_e;

  typedef struct packed {
    row_op_e                op;
    logic [CFG_DATA_W-1:0]  arg;
    row_exp_e               how;
    pix_t                   val;
    logic                   last;
  } script_row_t;

  // directed frames, results worked out by hand where they are obvious
  script_row_t script [TABLE_ROWS] = '{
    // 3x3 frame: 0 255 7 / 255 255 0 / 9 0 200
    '{OP_SET_WIDTH,  12'd3,   EXP_NONE,  8'd0,   1'b0},
    '{OP_SET_HEIGHT, 12'd3,   EXP_NONE,  8'd0,   1'b0},
    '{OP_PIXEL,      12'd0,   EXP_NONE,  8'd0,   1'b0},
    '{OP_DRAIN,      12'd0,   EXP_NONE,  8'd0,   1'b0},   // drain inside the frame is dropped
    '{OP_PIXEL,      12'd255, EXP_NONE,  8'd0,   1'b0},
    '{OP_PIXEL,      12'd7,   EXP_NONE,  8'd0,   1'b0},
    '{OP_PIXEL,      12'd255, EXP_NONE,  8'd0,   1'b0},
    '{OP_PIXEL,      12'd255, EXP_PIXEL, 8'd0,   1'b0},
    '{OP_PIXEL,      12'd0,   EXP_PIXEL, 8'd255, 1'b0},
    '{OP_PIXEL,      12'd9,   EXP_PIXEL, 8'd7,   1'b0},
    '{OP_PIXEL,      12'd0,   EXP_PIXEL, 8'd255, 1'b0},
    '{OP_PIXEL,      12'd200, EXP_PIXEL, 8'd9,   1'b0},   // centre takes the median
    '{OP_DRAIN,      12'd0,   EXP_PIXEL, 8'd0,   1'b0},
    '{OP_PIXEL,      12'd123, EXP_PIXEL, 8'd9,   1'b0},   // pixel past the end drains
    '{OP_DRAIN,      12'd255, EXP_PIXEL, 8'd0,   1'b0},
    '{OP_DRAIN,      12'd0,   EXP_PIXEL, 8'd200, 1'b1},
    // zero width and height behave as one
    '{OP_SET_WIDTH,  12'd0,   EXP_NONE,  8'd0,   1'b0},
    '{OP_SET_HEIGHT, 12'd0,   EXP_NONE,  8'd0,   1'b0},
    '{OP_PIXEL,      12'd77,  EXP_NONE,  8'd0,   1'b0},
    '{OP_DRAIN,      12'd0,   EXP_NONE,  8'd0,   1'b0},
    '{OP_DRAIN,      12'd0,   EXP_PIXEL, 8'd77,  1'b1},
    // 2x2 frame, restarted part way by a register write
    '{OP_SET_WIDTH,  12'd2,   EXP_NONE,    8'd0, 1'b0},
    '{OP_SET_HEIGHT, 12'd2,   EXP_NONE,    8'd0, 1'b0},
    '{OP_PIXEL,      12'd10,  EXP_PREDICT, 8'd0, 1'b0},
    '{OP_PIXEL,      12'd20,  EXP_PREDICT, 8'd0, 1'b0},
    '{OP_SET_HEIGHT, 12'd2,   EXP_NONE,    8'd0, 1'b0},
    '{OP_PIXEL,      12'd40,  EXP_PREDICT, 8'd0, 1'b0},
    '{OP_PIXEL,      12'd50,  EXP_PREDICT, 8'd0, 1'b0},
    '{OP_PIXEL,      12'd60,  EXP_PREDICT, 8'd0, 1'b0},
    '{OP_PIXEL,      12'd70,  EXP_PREDICT, 8'd0, 1'b0},
    '{OP_DRAIN,      12'd0,   EXP_PREDICT, 8'd0, 1'b0},
    '{OP_PIXEL,      12'd5,   EXP_PREDICT, 8'd0, 1'b0},
    '{OP_DRAIN,      12'd0,   EXP_PREDICT, 8'd0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  median_filter_3x3 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // predictor state
  logic [FWIDTH_BITS-1:0]  width_reg;
  logic [FHEIGHT_BITS-1:0] height_reg;
  pix_t                    upper_line  [MAX_WIDTH];
  pix_t                    middle_line [MAX_WIDTH];
  window_t                 win;
  col_t                    next_col;
  irow_t                   next_row;
  logic [COUNT_W-1:0]      pixels_out;

  // expected results and tallies
  out_item_t expected_pixels [$];
  int mismatches      = 0;
  int results_checked = 0;
  int frames_done     = 0;
  int requests_sent   = 0;
  int dropped_drains  = 0;
  int reg_writes      = 0;
  int burst_left      = 0;

  // receiver stall pattern
  int  stall_mode = 0;
  int  mode_left  = 0;
  int  stall_run  = 0;
  logic stall_next;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic weff_t eff_width();
    if (width_reg == '0) return weff_t'(1);
    if (width_reg > MAX_WIDTH) return weff_t'(MAX_WIDTH);
    return weff_t'(width_reg);
  endfunction

  function automatic orow_t eff_height();
    return (height_reg == '0) ? orow_t'(1) : height_reg;
  endfunction

  function automatic void restart_frame();
    win        = '0;
    next_col   = '0;
    next_row   = '0;
    pixels_out = '0;
  endfunction

  function automatic void set_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = val[FWIDTH_BITS-1:0];
    end else begin
      height_reg = val[FHEIGHT_BITS-1:0];
    end
    restart_frame();
  endfunction

  // fifth smallest of the nine, by rank counting
  function automatic pix_t median_of(input window_t w);
    int below;
    int same;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      same  = 0;
      for (int j = 0; j < 9; j++) begin
        if (w[j] < w[i]) below++;
        else if (w[j] == w[i]) same++;
      end
      if (below <= 4 && below + same > 4) return w[i];
    end
    return w[4];
  endfunction

  // advance the filter by one accepted request; returns 1 when it gives a pixel
  function automatic bit filter_step(input in_item_t req, output out_item_t res);
    weff_t              w;
    orow_t              h;
    logic [COUNT_W-1:0] total;
    pix_t               v;
    col_t               c;
    bit                 in_frame;
    bit                 emit;
    bit                 interior;
    int unsigned        orow;
    int unsigned        ocol;
    w        = eff_width();
    h        = eff_height();
    total    = w * h;
    in_frame = next_row < h;
    res      = '0;
    if (req.kind == KIND_DRAIN && in_frame) return 1'b0;
    v = in_frame ? req.pixel_value : '0;
    c = next_col;
    // shift the window left and bring in the new column
    for (int r = 0; r < 3; r++) begin
      win[r*3]     = win[r*3 + 1];
      win[r*3 + 1] = win[r*3 + 2];
    end
    win[2] = upper_line[c];
    win[5] = middle_line[c];
    win[8] = v;
    upper_line[c]  = middle_line[c];
    middle_line[c] = v;
    emit = (next_row >= 2 || (next_row == 1 && next_col >= 1)) && pixels_out < total;
    if (weff_t'(next_col) + weff_t'(1) >= w) begin
      next_col = '0;
      next_row = next_row + 1'b1;
    end else begin
      next_col = next_col + 1'b1;
    end
    if (!emit) return 1'b0;
    // border pixels pass, interior ones take the median
    orow     = pixels_out / w;
    ocol     = pixels_out % w;
    interior = orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w;
    res.filtered_value = interior ? median_of(win) : win[4];
    pixels_out = pixels_out + 1'b1;
    res.last_of_frame = (pixels_out == total);
    if (res.last_of_frame) restart_frame();
    return 1'b1;
  endfunction

  function automatic pix_t pick_pixel(input int style);
    case (style)
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return pix_t'($urandom_range(120, 127));
      3:       return pix_t'($urandom_range(0, 3) * 85);
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s: expected value %0d last %0b, got value %0d last %0b",
               $realtime, what, want.filtered_value, want.last_of_frame,
               got.filtered_value, got.last_of_frame);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("result with nothing expected", '0, out_data);
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (out_data.filtered_value !== want.filtered_value)
          note_mismatch("filtered_value", want, out_data);
        if (out_data.last_of_frame !== want.last_of_frame)
          note_mismatch("last_of_frame", want, out_data);
        if (want.last_of_frame) frames_done++;
      end
    end
  end

  // receiver stall pattern, in modes that change at random
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(32, 400);
    end
    mode_left--;
    case (stall_mode)
      1:       stall_next = ($urandom_range(0, 7) == 0);
      2:       stall_next = ($urandom_range(0, 3) != 0);
      3:       stall_next = (mode_left % 3 == 0);
      default: stall_next = 1'b0;
    endcase
    if (stall_run >= MAX_STALL_RUN) stall_next = 1'b0;
    stall_run = stall_next ? stall_run + 1 : 0;
    out_stall <= stall_next;
  end

  // one request through the handshake; called and returning at a falling edge
  task automatic send_request(input in_item_t req, input row_exp_e how,
                              input out_item_t typed);
    out_item_t res;
    bit        got;
    int        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = filter_step(req, res);
    case (how)
      EXP_PIXEL:   expected_pixels.push_back(typed);
      EXP_PREDICT: if (got) expected_pixels.push_back(res);
      default:     ;
    endcase
    @(negedge clk);
  endtask

  // drop valid and let the block run dry
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    set_register(idx, val);
    reg_writes++;
    @(negedge clk);
  endtask

  // pixels of a frame with the odd dropped drain, then, when with_tail is set, the draining tail
  task automatic send_frame(input int pixels, input int style, input bit with_tail);
    in_item_t req;
    int       tail;
    for (int k = 0; k < pixels; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        req.kind        = KIND_DRAIN;
        req.pixel_value = pix_t'($urandom);
        send_request(req, EXP_PREDICT, '0);
        dropped_drains++;
      end
      req.kind        = KIND_PIXEL;
      req.pixel_value = pick_pixel(style);
      send_request(req, EXP_PREDICT, '0);
      requests_sent++;
    end
    if (with_tail) begin
      tail = eff_width() + 1;
      for (int k = 0; k < tail; k++) begin
        req.kind        = $urandom_range(0, 1) ? KIND_DRAIN : KIND_PIXEL;
        req.pixel_value = pix_t'($urandom);
        send_request(req, EXP_PREDICT, '0);
        requests_sent++;
      end
    end
  endtask

  // cycle limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("run stopped at the cycle limit, %0d results still awaited",
             expected_pixels.size());
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    in_item_t  req;
    out_item_t typed;
    int        start_count;
    int        style;
    int        total;
    logic [FWIDTH_BITS-1:0]  new_width;
    logic [FHEIGHT_BITS-1:0] new_height;
    logic                    width_top;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_FRAME_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;

    width_reg  = FWIDTH_BITS'(640);
    height_reg = FHEIGHT_BITS'(480);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    restart_frame();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // hand-worked frames
    foreach (script[i]) begin
      case (script[i].op)
        OP_SET_WIDTH: begin
          wait_idle();
          write_register(CFG_FRAME_WIDTH, script[i].arg);
        end
        OP_SET_HEIGHT: begin
          wait_idle();
          write_register(CFG_FRAME_HEIGHT, script[i].arg);
        end
        default: begin
          req.kind             = (script[i].op == OP_DRAIN) ? KIND_DRAIN : KIND_PIXEL;
          req.pixel_value      = script[i].arg[PIXEL_BITS-1:0];
          typed.filtered_value = script[i].val;
          typed.last_of_frame  = script[i].last;
          send_request(req, script[i].how, typed);
          requests_sent++;
        end
      endcase
    end

    // width above the store clamps to it; frame cut short after the first row
    wait_idle();
    write_register(CFG_FRAME_WIDTH, 12'd2047);
    write_register(CFG_FRAME_HEIGHT, 12'd2);
    send_frame(1030, 0, 1'b0);

    // tallest frame, one column wide, cut short
    wait_idle();
    write_register(CFG_FRAME_WIDTH, 12'd1);
    write_register(CFG_FRAME_HEIGHT, 12'd4095);
    send_frame(40, 3, 1'b0);

    // random frames, mostly small
    start_count = requests_sent;
    while (requests_sent - start_count < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       new_width = '0;
        1:       new_width = FWIDTH_BITS'($urandom_range(1, 2));
        7, 8:    new_width = FWIDTH_BITS'($urandom_range(9, 24));
        9:       new_width = FWIDTH_BITS'($urandom_range(25, 48));
        default: new_width = FWIDTH_BITS'($urandom_range(3, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       new_height = '0;
        1:       new_height = FHEIGHT_BITS'($urandom_range(1, 2));
        8, 9:    new_height = FHEIGHT_BITS'($urandom_range(7, 10));
        default: new_height = FHEIGHT_BITS'($urandom_range(3, 6));
      endcase
      // spare top bit of the data bus on width writes
      width_top = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 3))
        0: write_register(CFG_FRAME_WIDTH, {width_top, new_width});
        1: write_register(CFG_FRAME_HEIGHT, new_height);
        default: begin
          write_register(CFG_FRAME_WIDTH, {width_top, new_width});
          write_register(CFG_FRAME_HEIGHT, new_height);
        end
      endcase
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        style = $urandom_range(0, 5);
        if (style > 3) style = 0;
        total = eff_width() * eff_height();
        if ($urandom_range(0, 9) == 0) begin
          send_frame($urandom_range(0, total - 1), style, 1'b0);
          break;
        end
        send_frame(total, style, 1'b1);
      end
    end

    wait_idle();

    $display("%0d requests (plus %0d dropped drains), %0d results checked, %0d frames closed",
             requests_sent, dropped_drains, results_checked, frames_done);
    $display("%0d register writes: zero, narrow and clamped full-width rows, heights to 4095",
             reg_writes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
